// ===== rtl/nbody_periodic_force_step_macros.svh =====
// Assertion helpers shared by the block's modules.
// Each expects a clock named clk and an active-high reset named rst in scope.
`ifndef NBODY_PERIODIC_FORCE_STEP_MACROS_SVH
`define NBODY_PERIODIC_FORCE_STEP_MACROS_SVH

// Same-cycle implication.
`define NBPFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NBPFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nbpfs_pkg.sv =====
`timescale 1ns / 1ps
package nbpfs_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int MAX_IMAGES    = 16;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = IDX_W + 1;

  // 0.0001 and 1/1.1 as fractions of 2^32
  localparam logic [18:0] SCALE_MUL = 19'd429497;
  localparam logic [31:0] DAMP_MUL  = 32'd3904515724;

  // shared divide / square-root unit sizing
  localparam int DU_NUM_W      = 57;
  localparam int DU_DEN_W      = 52;
  localparam int DU_DIV_STEPS  = 57;
  localparam int DU_SQRT_STEPS = 26;

  // configuration register indexes
  localparam logic CFG_PARTICLE_COUNT = 1'b0;
  localparam logic CFG_IMAGE_COUNT    = 1'b1;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } du_op_t;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         out_slot;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic                go;
    du_op_t              op;
    logic [DU_NUM_W-1:0] num;
    logic [DU_DEN_W-1:0] den;
  } du_req_t;

  typedef struct packed {
    logic                done;
    logic [DU_NUM_W-1:0] result;
  } du_rsp_t;

endpackage

// ===== rtl/nbpfs_ram.sv =====
`timescale 1ns / 1ps
module nbpfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write through the single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/nbpfs_divsqrt.sv =====
`timescale 1ns / 1ps
`include "nbody_periodic_force_step_macros.svh"
module nbpfs_divsqrt
  import nbpfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  du_req_t req,
  output du_rsp_t rsp
);

  logic                busy;
  logic                done;
  du_op_t              op_r;
  logic [5:0]          cnt;
  logic [DU_NUM_W:0]   rem;
  logic [DU_NUM_W-1:0] quo;
  logic [DU_NUM_W-1:0] nsh;
  logic [DU_DEN_W-1:0] den_r;

  logic [DU_NUM_W:0]   rem_sh;
  logic [DU_NUM_W:0]   trial;
  logic                fits;
  logic [DU_NUM_W:0]   diff;

  // one restoring step: one bit of quotient or one bit of root
  always_comb begin
    if (op_r == OP_DIV) begin
      rem_sh = {rem[DU_NUM_W-1:0], nsh[DU_NUM_W-1]};
      trial  = {{(DU_NUM_W+1-DU_DEN_W){1'b0}}, den_r};
    end else begin
      rem_sh = {rem[DU_NUM_W-2:0], nsh[DU_NUM_W-1:DU_NUM_W-2]};
      trial  = {quo[DU_NUM_W-2:0], 2'b01};
    end
    fits = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  // load on go, then iterate until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy  <= 1'b1;
        op_r  <= req.op;
        cnt   <= (req.op == OP_DIV) ? 6'(DU_DIV_STEPS) : 6'(DU_SQRT_STEPS);
        rem   <= '0;
        quo   <= '0;
        nsh   <= req.num;
        den_r <= req.den;
      end else if (busy) begin
        rem <= fits ? diff : rem_sh;
        quo <= {quo[DU_NUM_W-2:0], fits};
        if (op_r == OP_DIV) begin
          nsh <= {nsh[DU_NUM_W-2:0], 1'b0};
        end else begin
          nsh <= {nsh[DU_NUM_W-3:0], 2'b00};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = quo;

  `NBPFS_ASSERT_IMP(a_no_go_while_busy, req.go, !busy, "divsqrt: start while busy")
  `NBPFS_ASSERT_NXT(a_go_starts_work, req.go, busy, "divsqrt: start did not take")
  `NBPFS_ASSERT_IMP(a_done_when_idle, rsp.done, !busy, "divsqrt: done while busy")

endmodule

// ===== rtl/nbody_periodic_force_step.sv =====
`timescale 1ns / 1ps
`include "nbody_periodic_force_step_macros.svh"
// Two-dimensional periodic particle stepper in Q8.24. A load word (req_type 0)
// writes one particle. A step word (req_type 1) sums the
// inverse-square force of every other particle and its image offsets onto
// each of the first particle_count particles, damps, moves and emits them in
// slot order, last set on the final one; in_stall stays high for the whole
// step. Each nonzero image term goes through the single shared
// divide/square-root unit (one 26-step root, then two 57-step divides per
// axis), so a step works through P*(P-1)*(m/2*2)^2 image terms, where P and m
// are the clamped counts.
module nbody_periodic_force_step
  import nbpfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_en,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_LAT_I, S_NEXT_J, S_LAT_J, S_TERM_E, S_SQ, S_SUM,
    S_SQRT, S_DIV_C, S_DIV_T, S_NEXT_OFF, S_AP_MUL, S_AP_ADD, S_WB_V,
    S_RD_D, S_LAT_D, S_DMP_MUL, S_DMP_UPD, S_OUT
  } state_t;

  state_t state;

  logic [6:0] particle_count;
  logic [4:0] image_count;
  logic [CNT_W-1:0] p_lim;
  logic [4:0] m_lim;
  logic signed [4:0] half;

  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic signed [4:0] xo;
  logic signed [4:0] yo;
  logic comp;

  logic signed [31:0] pxi, pyi, vxi, vyi, pxj, pyj;
  logic signed [25:0] ex, ey;
  logic [24:0] ax, ay;
  logic [49:0] sqx, sqy;
  logic [51:0] s;
  logic [25:0] d;
  logic signed [46:0] fx, fy;
  logic [64:0] prx, pry;
  logic [63:0] dpx, dpy;

  du_req_t du_req;
  du_rsp_t du_rsp;

  // stores: {x, y} per slot
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [63:0]      pos_wdata, vel_wdata, pos_rdata, vel_rdata;

  // clamped counts
  assign p_lim = (particle_count > 7'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                      : CNT_W'(particle_count);
  assign m_lim = (image_count > 5'(MAX_IMAGES)) ? 5'(MAX_IMAGES) : image_count;
  assign half  = signed'({1'b0, m_lim[4:1]});

  // image separation, truncated to Q16 toward zero
  logic signed [33:0] dx, dy, dx_adj, dy_adj;
  logic signed [25:0] ex_n, ey_n;
  assign dx = 34'(pxi) - 34'(pxj) - (34'(xo) <<< 24);
  assign dy = 34'(pyi) - 34'(pyj) - (34'(yo) <<< 24);
  assign dx_adj = dx[33] ? dx + 34'sd255 : dx;
  assign dy_adj = dy[33] ? dy + 34'sd255 : dy;
  assign ex_n = dx_adj[33:8];
  assign ey_n = dy_adj[33:8];

  // signed term accumulate with clamp to +-2^45
  localparam logic signed [57:0] FCLAMP = 58'sd35184372088832;
  logic signed [57:0] t_s, f_sum, f_cl;
  logic t_neg;
  assign t_neg = comp ? ey[25] : ex[25];
  assign t_s   = t_neg ? -signed'({1'b0, du_rsp.result}) : signed'({1'b0, du_rsp.result});
  assign f_sum = (comp ? 58'(fy) : 58'(fx)) + t_s;
  assign f_cl  = (f_sum > FCLAMP) ? FCLAMP : ((f_sum < -FCLAMP) ? -FCLAMP : f_sum);

  // force magnitudes for the scale multiply
  logic [45:0] mfx, mfy;
  logic signed [46:0] nfx, nfy;
  assign nfx = -fx;
  assign nfy = -fy;
  assign mfx = fx[46] ? nfx[45:0] : fx[45:0];
  assign mfy = fy[46] ? nfy[45:0] : fy[45:0];

  // velocity plus scaled force, saturated
  logic [65:0] crx, cry;
  logic signed [34:0] avx, avy;
  logic signed [31:0] avx_s, avy_s;
  assign crx = 66'(prx) + 66'h80000000;
  assign cry = 66'(pry) + 66'h80000000;
  assign avx = 35'(vxi) + (fx[46] ? -signed'({2'b0, crx[64:32]})
                                  : signed'({2'b0, crx[64:32]}));
  assign avy = 35'(vyi) + (fy[46] ? -signed'({2'b0, cry[64:32]})
                                  : signed'({2'b0, cry[64:32]}));
  assign avx_s = (avx > 35'sd2147483647) ? 32'sh7fffffff :
                 ((avx < -35'sd2147483648) ? 32'sh80000000 : avx[31:0]);
  assign avy_s = (avy > 35'sd2147483647) ? 32'sh7fffffff :
                 ((avy < -35'sd2147483648) ? 32'sh80000000 : avy[31:0]);

  // damping and position update
  logic [31:0] mvx, mvy;
  logic [64:0] drx, dry;
  logic signed [32:0] dvx, dvy;
  logic signed [33:0] npx, npy;
  logic signed [31:0] npx_s, npy_s;
  assign mvx = vxi[31] ? 32'(-33'(vxi)) : vxi;
  assign mvy = vyi[31] ? 32'(-33'(vyi)) : vyi;
  assign drx = 65'(dpx) + 65'h80000000;
  assign dry = 65'(dpy) + 65'h80000000;
  assign dvx = vxi[31] ? -signed'({1'b0, drx[63:32]}) : signed'({1'b0, drx[63:32]});
  assign dvy = vyi[31] ? -signed'({1'b0, dry[63:32]}) : signed'({1'b0, dry[63:32]});
  assign npx = 34'(pxi) + 34'(dvx);
  assign npy = 34'(pyi) + 34'(dvy);
  assign npx_s = (npx > 34'sd2147483647) ? 32'sh7fffffff :
                 ((npx < -34'sd2147483648) ? 32'sh80000000 : npx[31:0]);
  assign npy_s = (npy > 34'sd2147483647) ? 32'sh7fffffff :
                 ((npy < -34'sd2147483648) ? 32'sh80000000 : npy[31:0]);

  logic [51:0] s_sum;
  assign s_sum = 52'(sqx) + 52'(sqy);

  // store port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = i[IDX_W-1:0];
    pos_wdata = {npx_s, npy_s};
    vel_wdata = {dvx[31:0], dvy[31:0]};
    case (state)
      S_IDLE: begin
        ram_addr  = in_word.slot;
        ram_we    = in_valid && (in_word.req_type == REQ_LOAD);
        pos_wdata = {in_word.pos_x, in_word.pos_y};
        vel_wdata = {in_word.vel_x, in_word.vel_y};
      end
      S_NEXT_J:  ram_addr = j[IDX_W-1:0];
      S_WB_V: begin
        ram_we    = 1'b1;
        pos_wdata = {pxi, pyi};
        vel_wdata = {vxi, vyi};
      end
      S_DMP_UPD: ram_we = 1'b1;
      default:   ram_addr = i[IDX_W-1:0];
    endcase
  end

  nbpfs_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(pos_wdata), .rdata(pos_rdata)
  );

  nbpfs_ram #(.WIDTH(64), .DEPTH(MAX_PARTICLES)) u_vel_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(vel_wdata), .rdata(vel_rdata)
  );

  nbpfs_divsqrt u_du (
    .clk(clk), .rst(rst), .req(du_req), .rsp(du_rsp)
  );

  assign in_stall = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= 7'd0;
      image_count    <= 5'd2;
    end else if (cfg_en) begin
      if (cfg_index == CFG_PARTICLE_COUNT) begin
        particle_count <= cfg_data;
      end else begin
        image_count <= cfg_data[4:0];
      end
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      du_req.go <= 1'b0;
    end else begin
      du_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          i <= '0;
          if (in_valid && in_word.req_type == REQ_STEP && p_lim != '0) begin
            state <= S_RD_I;
          end
        end
        S_RD_I: begin
          j     <= '0;
          state <= S_LAT_I;
        end
        S_LAT_I: begin
          {pxi, pyi} <= pos_rdata;
          {vxi, vyi} <= vel_rdata;
          state      <= S_NEXT_J;
        end
        S_NEXT_J: begin
          if (j == p_lim) begin
            state <= S_WB_V;
          end else if (j == i) begin
            j <= j + 1'b1;
          end else begin
            state <= S_LAT_J;
          end
        end
        S_LAT_J: begin
          {pxj, pyj} <= pos_rdata;
          fx    <= '0;
          fy    <= '0;
          xo    <= -half;
          yo    <= -half;
          comp  <= 1'b0;
          state <= (half == 5'sd0) ? S_AP_MUL : S_TERM_E;
        end
        S_TERM_E: begin
          ex    <= ex_n;
          ey    <= ey_n;
          ax    <= ex_n[25] ? 25'(-ex_n) : ex_n[24:0];
          ay    <= ey_n[25] ? 25'(-ey_n) : ey_n[24:0];
          state <= S_SQ;
        end
        S_SQ: begin
          sqx   <= ax * ax;
          sqy   <= ay * ay;
          state <= S_SUM;
        end
        S_SUM: begin
          s <= s_sum;
          if (s_sum == '0) begin
            state <= S_NEXT_OFF;
          end else begin
            du_req.go  <= 1'b1;
            du_req.op  <= OP_SQRT;
            du_req.num <= {s_sum, 5'd0};
            du_req.den <= '0;
            state      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (du_rsp.done) begin
            d          <= du_rsp.result[25:0];
            du_req.go  <= 1'b1;
            du_req.op  <= OP_DIV;
            du_req.num <= {2'b0, ax, 30'd0};
            du_req.den <= {26'd0, du_rsp.result[25:0]};
            state      <= S_DIV_C;
          end
        end
        S_DIV_C: begin
          if (du_rsp.done) begin
            du_req.go  <= 1'b1;
            du_req.op  <= OP_DIV;
            du_req.num <= {du_rsp.result[30:0], 26'd0};
            du_req.den <= s;
            state      <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          if (du_rsp.done) begin
            if (!comp) begin
              fx         <= f_cl[46:0];
              comp       <= 1'b1;
              du_req.go  <= 1'b1;
              du_req.op  <= OP_DIV;
              du_req.num <= {2'b0, ay, 30'd0};
              du_req.den <= {26'd0, d};
              state      <= S_DIV_C;
            end else begin
              fy    <= f_cl[46:0];
              comp  <= 1'b0;
              state <= S_NEXT_OFF;
            end
          end
        end
        S_NEXT_OFF: begin
          if (yo + 5'sd1 == half) begin
            yo <= -half;
            xo <= xo + 5'sd1;
            state <= (xo + 5'sd1 == half) ? S_AP_MUL : S_TERM_E;
          end else begin
            yo    <= yo + 5'sd1;
            state <= S_TERM_E;
          end
        end
        S_AP_MUL: begin
          prx   <= mfx * SCALE_MUL;
          pry   <= mfy * SCALE_MUL;
          state <= S_AP_ADD;
        end
        S_AP_ADD: begin
          vxi   <= avx_s;
          vyi   <= avy_s;
          j     <= j + 1'b1;
          state <= S_NEXT_J;
        end
        S_WB_V: begin
          if (i + 1'b1 == p_lim) begin
            i <= '0;
            state <= S_RD_D;
          end else begin
            i <= i + 1'b1;
            state <= S_RD_I;
          end
        end
        S_RD_D: begin
          state <= S_LAT_D;
        end
        S_LAT_D: begin
          {pxi, pyi} <= pos_rdata;
          {vxi, vyi} <= vel_rdata;
          state      <= S_DMP_MUL;
        end
        S_DMP_MUL: begin
          dpx   <= mvx * DAMP_MUL;
          dpy   <= mvy * DAMP_MUL;
          state <= S_DMP_UPD;
        end
        S_DMP_UPD: begin
          out_word.out_slot  <= i[IDX_W-1:0];
          out_word.new_pos_x <= npx_s;
          out_word.new_pos_y <= npy_s;
          out_word.new_vel_x <= dvx[31:0];
          out_word.new_vel_y <= dvy[31:0];
          out_word.last      <= (i + 1'b1 == p_lim);
          out_valid          <= 1'b1;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_word.last) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_RD_D;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NBPFS_ASSERT_IMP(a_out_holds_input, out_valid, in_stall, "output pending while accepting")
  `NBPFS_ASSERT_NXT(a_idle_after_last, out_valid && !out_stall && out_word.last,
                    !out_valid && !in_stall, "not idle after last particle")
  `NBPFS_ASSERT_IMP(a_slot_in_run, out_valid, {1'b0, out_word.out_slot} < p_lim,
                    "emitted slot beyond particle count")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import nbpfs_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_GAP  = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_en;
  logic      cfg_index;
  logic [6:0] cfg_data;

  nbody_periodic_force_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // particle state as the block should hold it
  logic signed [31:0] pos_x_mem [MAX_PARTICLES];
  logic signed [31:0] pos_y_mem [MAX_PARTICLES];
  logic signed [31:0] vel_x_mem [MAX_PARTICLES];
  logic signed [31:0] vel_y_mem [MAX_PARTICLES];
  logic [6:0] particle_reg;
  logic [4:0] image_reg;

  in_word_t  pending_words[$];
  out_word_t expected_particles[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_sum(longint v);
    longint lim;
    lim = 64'sd35184372088832;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint axis_term(longint e, longint unsigned s, longint unsigned d);
    longint unsigned c;
    longint t;
    c = (magnitude(e) << 30) / d;
    t = longint'((c << 26) / s);
    return e < 0 ? -t : t;
  endfunction

  // add 0.0001 of the pair force, saturate
  function automatic logic signed [31:0] kick(logic signed [31:0] v, longint f);
    longint c;
    c = longint'((magnitude(f) * 64'(SCALE_MUL) + 64'd2147483648) >> 32);
    return 32'(sat_word(longint'(v) + (f < 0 ? -c : c)));
  endfunction

  function automatic longint damped(logic signed [31:0] v);
    longint m;
    m = longint'((magnitude(longint'(v)) * 64'(DAMP_MUL) + 64'd2147483648) >> 32);
    return v < 0 ? -m : m;
  endfunction

  // advance all stepped particles and queue the words they produce
  task automatic advance_particles();
    int np;
    int half;
    longint fx, fy, dx, dy, ex, ey, vx, vy, nx, ny;
    longint unsigned s, d;
    out_word_t w;
    np = particle_reg > MAX_PARTICLES ? MAX_PARTICLES : particle_reg;
    half = (image_reg > MAX_IMAGES ? MAX_IMAGES : image_reg) / 2;
    for (int i = 0; i < np; i++) begin
      for (int j = 0; j < np; j++) begin
        if (i == j) continue;
        fx = 0;
        fy = 0;
        for (int xo = -half; xo < half; xo++) begin
          for (int yo = -half; yo < half; yo++) begin
            dx = longint'(pos_x_mem[i]) - longint'(pos_x_mem[j]) - longint'(xo) * 16777216;
            dy = longint'(pos_y_mem[i]) - longint'(pos_y_mem[j]) - longint'(yo) * 16777216;
            ex = dx / 256;
            ey = dy / 256;
            s = magnitude(ex) * magnitude(ex) + magnitude(ey) * magnitude(ey);
            // coincident image: skip
            if (s == 0) continue;
            d = int_sqrt(s);
            fx = clamp_sum(fx + axis_term(ex, s, d));
            fy = clamp_sum(fy + axis_term(ey, s, d));
          end
        end
        vel_x_mem[i] = kick(vel_x_mem[i], fx);
        vel_y_mem[i] = kick(vel_y_mem[i], fy);
      end
    end
    for (int i = 0; i < np; i++) begin
      vx = damped(vel_x_mem[i]);
      vy = damped(vel_y_mem[i]);
      nx = sat_word(longint'(pos_x_mem[i]) + vx);
      ny = sat_word(longint'(pos_y_mem[i]) + vy);
      vel_x_mem[i] = 32'(vx);
      vel_y_mem[i] = 32'(vy);
      pos_x_mem[i] = 32'(nx);
      pos_y_mem[i] = 32'(ny);
      w.out_slot  = 6'(i);
      w.new_pos_x = 32'(nx);
      w.new_pos_y = 32'(ny);
      w.new_vel_x = 32'(vx);
      w.new_vel_y = 32'(vy);
      w.last      = (i + 1 == np);
      expected_particles.push_back(w);
    end
  endtask

  task automatic accept_word(in_word_t w);
    if (w.req_type == REQ_LOAD) begin
      pos_x_mem[w.slot] = w.pos_x;
      pos_y_mem[w.slot] = w.pos_y;
      vel_x_mem[w.slot] = w.vel_x;
      vel_y_mem[w.slot] = w.vel_y;
    end else begin
      advance_particles();
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (expected_particles.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected output word: %p", got);
      return;
    end
    want = expected_particles.pop_front();
    if (got.out_slot != want.out_slot || got.new_pos_x != want.new_pos_x ||
        got.new_pos_y != want.new_pos_y || got.new_vel_x != want.new_vel_x ||
        got.new_vel_y != want.new_vel_y || got.last != want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected %p actual %p", want, got);
    end
  endtask

  // drive input words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) accept_word(in_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // collect output words, stall at random or for a long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_word(out_word);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  task automatic queue_load(int s, logic [31:0] px, logic [31:0] py,
                            logic [31:0] vx, logic [31:0] vy);
    in_word_t w;
    w.req_type = REQ_LOAD;
    w.slot     = 6'(s);
    w.pos_x    = px;
    w.pos_y    = py;
    w.vel_x    = vx;
    w.vel_y    = vy;
    pending_words.push_back(w);
  endtask

  task automatic queue_random_load(int s);
    queue_load(s, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic queue_step();
    in_word_t w;
    w.req_type = REQ_STEP;
    w.slot     = 6'($urandom);
    w.pos_x    = $urandom;
    w.pos_y    = $urandom;
    w.vel_x    = $urandom;
    w.vel_y    = $urandom;
    pending_words.push_back(w);
  endtask

  // hold until the block has drained everything
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_particles.size() != 0);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] value);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_PARTICLE_COUNT) particle_reg = value;
    else image_reg = value[4:0];
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  initial begin
    int np;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_word        = '0;
    out_stall      = 1'b0;
    cfg_en         = 1'b0;
    cfg_index      = CFG_PARTICLE_COUNT;
    cfg_data       = '0;
    particle_reg   = 7'd0;
    image_reg      = 5'd2;
    tx_idle_pct    = 8;
    rx_idle_pct    = 65;
    rx_hold_left   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty step, then extremes and a coincident pair
    queue_step();
    queue_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_load(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_load(2, 32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0);
    queue_load(3, 32'h0100_0000, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_load(63, 32'hFFFF_FFFF, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA);
    for (int s = 4; s < 8; s++) queue_random_load(s);
    settle();
    write_reg(CFG_PARTICLE_COUNT, 7'd2);
    queue_step();
    settle();
    write_reg(CFG_PARTICLE_COUNT, 7'd4);
    queue_step();
    settle();
    write_reg(CFG_IMAGE_COUNT, 7'd1);
    queue_step();
    settle();
    write_reg(CFG_IMAGE_COUNT, 7'd0);
    queue_step();
    settle();
    write_reg(CFG_PARTICLE_COUNT, 7'd2);
    write_reg(CFG_IMAGE_COUNT, 7'd31);
    queue_step();
    settle();

    // random part: short reconfigured bursts of loads and steps
    for (int chunk = 0; chunk < 6; chunk++) begin
      if (chunk == 2) begin
        tx_idle_pct = 65;
        rx_idle_pct = 8;
      end else if (chunk == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      np = $urandom_range(2, 4);
      write_reg(CFG_PARTICLE_COUNT, 7'(np));
      write_reg(CFG_IMAGE_COUNT, 7'($urandom_range(0, 3)));
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(3) == 0) queue_step();
        else if ($urandom_range(4) == 0) queue_random_load($urandom_range(0, 63));
        else queue_random_load($urandom_range(0, np - 1));
      end
      queue_step();
      // long receiver hold while words keep coming
      if (chunk == 4) begin
        settle();
        write_reg(CFG_IMAGE_COUNT, 7'd0);
        rx_hold_left = 3000;
        for (int k = 0; k < 4; k++) begin
          queue_step();
          queue_random_load($urandom_range(0, np - 1));
        end
      end
      settle();
    end

    // full store, counts at and beyond the top
    for (int s = 0; s < MAX_PARTICLES; s++) queue_random_load(s);
    settle();
    write_reg(CFG_PARTICLE_COUNT, 7'd64);
    write_reg(CFG_IMAGE_COUNT, 7'd0);
    queue_step();
    settle();
    write_reg(CFG_PARTICLE_COUNT, 7'd127);
    write_reg(CFG_IMAGE_COUNT, 7'd1);
    queue_step();
    settle();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
